### rtl/core/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and codes of the stuffed bit reader.
// ----------------------------------------------------------------------------
package sbr_pkg;

	// request opcodes
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_ALIGN = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	localparam logic [7:0] BYTE_FF   = 8'hFF;
	localparam logic [5:0] MAX_BITS  = 6'd32;
	localparam logic [5:0] MAX_BYTES = 6'd4;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// decoded request handed from front to back
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] byte_val;
		logic [5:0] count;
		logic [5:0] nbits;
		logic       is_zero;
		logic       is_skip;
	} sbr_cmd_t;

endpackage

### rtl/core/sbr_if.sv
// ----------------------------------------------------------------------------
// sbr_if
// Valid/ready channels for requests and results of the stuffed bit reader.
// ----------------------------------------------------------------------------
interface sbr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] byte_in;
	logic [5:0] count;

	modport source(output valid, output opcode, output byte_in, output count, input ready);
	modport sink(input valid, input opcode, input byte_in, input count, output ready);
endinterface

interface sbr_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic [1:0]  status;

	modport source(output valid, output value, output status, input ready);
	modport sink(input valid, input value, input status, output ready);
endinterface

### rtl/core/sbr_front.sv
// ----------------------------------------------------------------------------
// sbr_front
// Takes requests and decodes them into commands for the back end.
// ----------------------------------------------------------------------------
module sbr_front (
	sbr_req_if.sink            req,
	input  logic               cmd_ready,
	output logic               cmd_push,
	output sbr_pkg::sbr_cmd_t  cmd
);

	always_comb begin
		req.ready    = cmd_ready;
		cmd_push     = req.valid && cmd_ready;
		cmd.op       = req.opcode;
		cmd.byte_val = req.byte_in;
		cmd.count    = req.count;
		// bit requests above 32 are clamped
		cmd.nbits    = (req.count > sbr_pkg::MAX_BITS) ? sbr_pkg::MAX_BITS : req.count;
		cmd.is_zero  = (req.count == 6'd0);
		cmd.is_skip  = (req.count > sbr_pkg::MAX_BYTES);
	end

endmodule

### rtl/core/sbr_fifo.sv
// ----------------------------------------------------------------------------
// sbr_fifo
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module sbr_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sbr_pkg::sbr_cmd_t  push_data,
	output logic               push_ready,
	input  logic               pop,
	output logic               pop_valid,
	output sbr_pkg::sbr_cmd_t  pop_data
);

	sbr_pkg::sbr_cmd_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && push_ready) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push && push_ready, pop && pop_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/sbr_back.sv
// ----------------------------------------------------------------------------
// sbr_back
// Byte queue and sequencer that carries out push, get bits, align and read.
// ----------------------------------------------------------------------------
module sbr_back #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  sbr_pkg::sbr_cmd_t  cmd_in,
	output logic               cmd_pop,
	output logic [3:0]         bits_used,
	sbr_res_if.source          rsp
);

	localparam int AW  = $clog2(DEPTH);
	localparam int FW  = $clog2(DEPTH + 1);
	localparam int SW  = ((FW > 6) ? FW : 6) + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_BITS  = 3'd2;
	localparam logic [2:0] S_ALIGN = 3'd3;
	localparam logic [2:0] S_RDB   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_q;
	logic [2:0]        state_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [FW-1:0]     fill_q;
	logic [3:0]        bused_q;
	sbr_pkg::sbr_cmd_t cmd_q;
	logic [FW-1:0]     pos_q;
	logic [3:0]        bit_q;
	logic [5:0]        cnt_q;
	logic [31:0]       acc_q;
	logic [31:0]       fin_value_q;
	logic [1:0]        fin_status_q;
	logic              out_valid_q;
	logic [31:0]       out_value_q;
	logic [1:0]        out_status_q;

	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic          wr_en;
	logic          is_full;
	logic          new_bit;
	logic [31:0]   bit_acc;
	logic [31:0]   byte_acc;
	logic          head_ff;
	logic          res_load;
	logic [1:0]    idle_status;

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
		logic [SW-1:0] t;
		t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
		return t[AW-1:0];
	endfunction

	assign cmd_pop    = (state_q == S_IDLE) && cmd_valid;
	assign is_full    = (fill_q == FW'(DEPTH));
	assign wr_en      = cmd_pop && (cmd_in.op == sbr_pkg::OP_PUSH) && !is_full;
	assign rd_en      = (state_q == S_FETCH);
	assign rd_addr    = wrap(SW'(head_q) + SW'(pos_q));
	assign new_bit    = rd_q[~bit_q[2:0]];
	assign bit_acc    = {acc_q[30:0], new_bit};
	assign byte_acc   = {acc_q[23:0], rd_q};
	assign head_ff    = (rd_q == sbr_pkg::BYTE_FF);
	assign bits_used  = bused_q;
	assign res_load   = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// status known at command pickup; get bits and align may still underflow
	always_comb begin
		case (cmd_in.op)
			sbr_pkg::OP_PUSH: idle_status = is_full ? sbr_pkg::ST_FULL : sbr_pkg::ST_OK;
			sbr_pkg::OP_READ: idle_status = (!cmd_in.is_zero &&
				(SW'(cmd_in.count) > SW'(fill_q))) ? sbr_pkg::ST_UNDERFLOW : sbr_pkg::ST_OK;
			default:          idle_status = sbr_pkg::ST_OK;
		endcase
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.value  = out_value_q;
	assign rsp.status = out_status_q;

	// byte store: one write port at the tail, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= cmd_in.byte_val;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			bused_q      <= '0;
			pos_q        <= '0;
			bit_q        <= '0;
			cnt_q        <= '0;
			acc_q        <= '0;
			fin_value_q  <= '0;
			fin_status_q <= sbr_pkg::ST_OK;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= sbr_pkg::ST_OK;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						pos_q        <= '0;
						cnt_q        <= '0;
						acc_q        <= '0;
						bit_q        <= bused_q;
						fin_value_q  <= '0;
						fin_status_q <= idle_status;
						case (cmd_in.op)
							sbr_pkg::OP_PUSH: begin
								state_q <= S_DONE;
								if (!is_full) begin
									tail_q <= wrap(SW'(tail_q) + SW'(1));
									fill_q <= fill_q + FW'(1);
								end
							end
							sbr_pkg::OP_GET: begin
								state_q <= cmd_in.is_zero ? S_DONE : S_FETCH;
							end
							sbr_pkg::OP_ALIGN: begin
								state_q <= (bused_q != 4'd0) ? S_FETCH : S_DONE;
							end
							sbr_pkg::OP_READ: begin
								if (cmd_in.is_zero) begin
									state_q <= S_DONE;
								end else if (SW'(cmd_in.count) > SW'(fill_q)) begin
									state_q <= S_DONE;
								end else if (cmd_in.is_skip) begin
									state_q <= S_DONE;
									head_q  <= wrap(SW'(head_q) + SW'(cmd_in.count));
									fill_q  <= FW'(SW'(fill_q) - SW'(cmd_in.count));
									bused_q <= '0;
								end else begin
									state_q <= S_FETCH;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FETCH: begin
					if (pos_q >= fill_q) begin
						fin_value_q  <= '0;
						fin_status_q <= sbr_pkg::ST_UNDERFLOW;
						state_q      <= S_DONE;
					end else begin
						case (cmd_q.op)
							sbr_pkg::OP_GET:   state_q <= S_BITS;
							sbr_pkg::OP_ALIGN: state_q <= S_ALIGN;
							default:           state_q <= S_RDB;
						endcase
					end
				end
				S_BITS: begin
					if (bit_q >= sbr_pkg::BITS_PER_BYTE) begin
						// byte used up: stuffed bit follows a 0xff byte
						bit_q   <= head_ff ? 4'd1 : 4'd0;
						pos_q   <= pos_q + FW'(1);
						state_q <= S_FETCH;
					end else begin
						acc_q <= bit_acc;
						bit_q <= bit_q + 4'd1;
						cnt_q <= cnt_q + 6'd1;
						if ((cnt_q + 6'd1) == cmd_q.nbits) begin
							head_q      <= wrap(SW'(head_q) + SW'(pos_q));
							fill_q      <= fill_q - pos_q;
							bused_q     <= bit_q + 4'd1;
							fin_value_q <= bit_acc;
							state_q     <= S_DONE;
						end
					end
				end
				S_ALIGN: begin
					state_q <= S_DONE;
					if (head_ff && (fill_q < FW'(2))) begin
						fin_status_q <= sbr_pkg::ST_UNDERFLOW;
					end else begin
						head_q  <= wrap(SW'(head_q) + (head_ff ? SW'(2) : SW'(1)));
						fill_q  <= fill_q - (head_ff ? FW'(2) : FW'(1));
						bused_q <= '0;
					end
				end
				S_RDB: begin
					acc_q <= byte_acc;
					cnt_q <= cnt_q + 6'd1;
					if ((cnt_q + 6'd1) == cmd_q.count) begin
						head_q      <= wrap(SW'(head_q) + SW'(cmd_q.count));
						fill_q      <= FW'(SW'(fill_q) - SW'(cmd_q.count));
						fin_value_q <= byte_acc;
						state_q     <= S_DONE;
					end else begin
						pos_q   <= pos_q + FW'(1);
						state_q <= S_FETCH;
					end
				end
				S_DONE: begin
					if (res_load) begin
						out_value_q  <= fin_value_q;
						out_status_q <= fin_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/stuffed_bit_reader.sv
// ----------------------------------------------------------------------------
// stuffed_bit_reader
// Packet header bit reader with bit unstuffing after 0xff bytes.
// ----------------------------------------------------------------------------
// usage
//   req channel: one request per handshake, opcode selects push byte,
//   get bits (0..32, msb first), byte align, or read 1..4 / skip 5+ bytes
//   rsp channel: exactly one result per request, value and status,
//   in request order
//   a front end decodes requests into a two-entry queue, so requests are
//   taken while the back end works or while a result waits to be taken
//   steps: push, align on a byte boundary, zero counts, skips and read
//   underflow go from pickup straight to the result register; get bits
//   fetches each byte from the store and shifts in its bits one at a
//   time; read bytes fetches and shifts in a byte at a time; align with
//   bits pending steps past the head byte, and the next one after 0xff
//   the back end runs one request at a time, one bit per cycle in a byte;
//   each byte boundary adds a fetch through the registered read port
//   reset clears queue pointers, fill level, bit position and both channels;
//   no clearing pass is needed
//   a stalled rsp holds its result; the back end then waits with the next
//   result and the request queue fills before req.ready drops
// ----------------------------------------------------------------------------
module stuffed_bit_reader #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sbr_req_if.sink    req,
	sbr_res_if.source  rsp
);

	// front to queue
	logic              cmd_push;
	logic              cmd_ready;
	sbr_pkg::sbr_cmd_t cmd_dec;

	// queue to back end
	logic              cmd_valid;
	logic              cmd_pop;
	sbr_pkg::sbr_cmd_t cmd_head;

	logic [3:0]        bits_used;

	// request decode
	sbr_front u_front (
		.req       (req),
		.cmd_ready (cmd_ready),
		.cmd_push  (cmd_push),
		.cmd       (cmd_dec)
	);

	// short queue so front and back stall independently
	sbr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_data  (cmd_dec),
		.push_ready (cmd_ready),
		.pop        (cmd_pop),
		.pop_valid  (cmd_valid),
		.pop_data   (cmd_head)
	);

	// byte store, bit sequencer and result register
	sbr_back #(
		.DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_in    (cmd_head),
		.cmd_pop   (cmd_pop),
		.bits_used (bits_used),
		.rsp       (rsp)
	);

`ifndef NO_ASSERTIONS
	// back end only takes a command that the queue holds
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command taken from empty queue");

	// failed requests carry a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != sbr_pkg::ST_OK)) |-> (rsp.value == 32'd0))
		else $error("non-zero value on failed request");

	// bit position within the head byte never passes a whole byte
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_used <= sbr_pkg::BITS_PER_BYTE)
		else $error("bit position out of range");

	// a waiting result holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.value) && $stable(rsp.status)))
		else $error("result changed while stalled");
`endif

endmodule
